[rtl/core/skt_pkg.sv]
// ============================================================================
// skt_pkg: shared types and constants for the sorted key table
// Holds the field types, operation and status codes, cell commands and the
// control state encoding used across the table's modules.
// ============================================================================
package skt_pkg;

    // Default number of cells in the table.
    localparam int CAPACITY_DEFAULT = 32;

    // Fixed field widths.
    localparam int KEY_W   = 24;
    localparam int FIELD_W = 6;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [FIELD_W-1:0] field_t;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_DUMP   = 2'd3
    } opcode_t;

    // Status codes carried by a result item.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Command broadcast to every cell in a cycle.
    typedef enum logic [2:0] {
        CM_HOLD    = 3'd0,
        CM_COMPARE = 3'd1,
        CM_INSERT  = 3'd2,
        CM_DELETE  = 3'd3,
        CM_ROTATE  = 3'd4
    } cell_mode_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DUMP = 2'd2
    } state_t;

    // Control bundle from the sequencer to the cells.
    typedef struct packed {
        cell_mode_t mode;
        key_t       key;
    } cell_ctl_t;

endpackage

[rtl/core/skt_if.sv]
// ============================================================================
// skt_if: request and response channels of the sorted key table
// Each channel carries valid, ready and its payload; an item moves at a rising
// clock edge with valid and ready both high.
// ============================================================================

// Request channel: one operation and its key per item.
interface skt_req_if;
    import skt_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    key_t    key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

// Response channel: one result per item.
interface skt_rsp_if;
    import skt_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    key_t    key_out;
    field_t  position;
    field_t  entry_count;
    logic    last;

    modport source (output valid, output status, output key_out, output position,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input key_out, input position,
                    input entry_count, input last, output ready);
endinterface

[rtl/core/sorted_key_table_core.sv]
// ============================================================================
// sorted_key_table_core: bounded table of 24-bit keys kept in ascending order
// Insert, search, delete and an in-order dump over a row of compare cells.
// ============================================================================
//
// The table keeps up to CAPACITY keys in a row of cells, one key per cell, in
// ascending order. For insert, search and delete, in the cycle that accepts
// the item every cell compares its key with the incoming one; then, once the
// output register is free, the cells shift one place up or down in parallel
// while the result is loaded into the output register. In a dump the
// occupied cells turn round as a ring by one slot per result item and the
// head cell is emitted each time; after the last item the order is as before.
// A new item is accepted while the previous result still waits on the
// output. The cells have no reset; only the entry count is cleared, and no
// cell at or above the count is ever read.
//
module sorted_key_table_core #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t           ctl;
    logic [CNT_W-1:0]    count;
    key_t                entry [CAPACITY];
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;

    // Sequencer and result register.
    skt_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .lt    (lt),
        .eq    (eq),
        .head  (entry[0]),
        .ctl   (ctl),
        .count (count)
    );

    // Row of cells, each wired to its neighbours; the ends see fixed values.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        key_t left_entry;
        logic left_lt;
        key_t right_entry;

        if (g == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_entry = entry[g-1];
            assign left_lt    = lt[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_inner_right
            assign right_entry = entry[g+1];
        end

        skt_cell #(
            .CAPACITY(CAPACITY),
            .IDX     (g)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count),
            .left_entry  (left_entry),
            .left_lt     (left_lt),
            .right_entry (right_entry),
            .head_entry  (entry[0]),
            .entry       (entry[g]),
            .lt          (lt[g]),
            .eq          (eq[g])
        );
    end

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // The count moves by at most one per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count) |-> (count == $past(count) + CNT_W'(1)) ||
                            (count == $past(count) - CNT_W'(1)))
        else $error("entry count jumped");

    // No new item is taken while the ring is turning for a dump.
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mode == CM_ROTATE |-> !req.ready)
        else $error("item accepted during dump");

    // A full report always shows the table at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STAT_FULL |-> rsp.entry_count == FIELD_W'(CAPACITY))
        else $error("full status with wrong count");

endmodule

[rtl/core/skt_cell.sv]
// ============================================================================
// skt_cell: one slot of the sorted key table
// Holds one key, compares it against the broadcast key and takes a key from
// its left or right neighbour, or from the head, when the table shifts.
// ============================================================================
module skt_cell #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
    parameter int IDX      = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  skt_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]   count,
    input  skt_pkg::key_t      left_entry,
    input  logic               left_lt,
    input  skt_pkg::key_t      right_entry,
    input  skt_pkg::key_t      head_entry,
    output skt_pkg::key_t      entry,
    output logic               lt,
    output logic               eq
);
    import skt_pkg::*;

    key_t entry_reg, entry_next;
    logic lt_reg, lt_next;
    logic eq_reg, eq_next;
    logic occupied;
    logic right_occupied;

    // Occupancy of this slot and of the one to its right.
    assign occupied       = CNT_W'(IDX) < count;
    assign right_occupied = CNT_W'(IDX + 1) < count;

    // Next key and comparison flags for the broadcast command.
    always_comb
    begin
        entry_next = entry_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        case (ctl.mode)
            CM_HOLD:
            begin
                entry_next = entry_reg;
            end
            CM_COMPARE:
            begin
                lt_next = occupied && (entry_reg < ctl.key);
                eq_next = occupied && (entry_reg == ctl.key);
            end
            CM_INSERT:
            begin
                // Slots at or above the insertion point move one place up.
                if (!lt_reg)
                begin
                    entry_next = left_lt ? ctl.key : left_entry;
                end
            end
            CM_DELETE:
            begin
                // Slots at or above the removed key move one place down.
                if (!lt_reg)
                begin
                    entry_next = right_entry;
                end
            end
            CM_ROTATE:
            begin
                // The occupied slots turn round by one, the head wrapping to the tail.
                entry_next = right_occupied ? right_entry : head_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

[rtl/core/skt_ctrl.sv]
// ============================================================================
// skt_ctrl: sequencer and result register of the sorted key table
// Accepts items, commands the row of cells, keeps the entry count, decodes
// the cell flags into a position and holds the result for the output.
// ============================================================================
module skt_ctrl #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    skt_req_if.sink             req,
    skt_rsp_if.source           rsp,
    input  logic [CAPACITY-1:0] lt,
    input  logic [CAPACITY-1:0] eq,
    input  skt_pkg::key_t       head,
    output skt_pkg::cell_ctl_t  ctl,
    output logic [CNT_W-1:0]    count
);
    import skt_pkg::*;

    state_t           state_reg, state_next;
    opcode_t          op_reg;
    key_t             key_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] dump_idx_reg, dump_idx_next;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg;
    key_t             out_key_reg;
    field_t           out_pos_reg;
    field_t           out_count_reg;
    logic             out_last_reg;

    status_t          res_status;
    key_t             res_key;
    field_t           res_pos;
    logic             res_last;
    logic             out_load;
    logic             out_free;

    logic             full;
    logic             empty;
    logic             dump_last;
    logic             found;
    logic [IDX_W-1:0] hit_pos;

    assign full      = count_reg == CNT_W'(CAPACITY);
    assign empty     = count_reg == '0;
    assign dump_last = (CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    // The lowest slot that is not below the key is where the less-than flags
    // stop; the flags form a run from slot zero because the keys are sorted.
    always_comb
    begin
        hit_pos = '0;
        found   = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!lt[i] && ((i == 0) || lt[(i == 0) ? 0 : i - 1]))
            begin
                hit_pos = hit_pos | IDX_W'(i);
                found   = found | eq[i];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_DUMP && !empty)
                begin
                    state_next = S_DUMP;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Cell commands, count update and result formation.
    always_comb
    begin
        req.ready     = 1'b0;
        ctl.mode      = CM_HOLD;
        ctl.key       = key_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        out_load      = 1'b0;
        res_status    = STAT_OK;
        res_key       = '0;
        res_pos       = '0;
        res_last      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                ctl.key   = req.key;
                if (req.valid)
                begin
                    ctl.mode = CM_COMPARE;
                end
            end
            S_EXEC:
            begin
                dump_idx_next = '0;
                out_load      = out_free && !(op_reg == OP_DUMP && !empty);
                if (op_reg == OP_INSERT)
                begin
                    if (full)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        res_key = key_reg;
                        res_pos = FIELD_W'(hit_pos);
                        if (out_free)
                        begin
                            ctl.mode   = CM_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else if (empty)
                begin
                    res_status = STAT_EMPTY;
                end
                else if (op_reg == OP_DUMP)
                begin
                    res_status = STAT_OK;
                end
                else if (found)
                begin
                    res_key = key_reg;
                    res_pos = FIELD_W'(hit_pos);
                    if (op_reg == OP_DELETE && out_free)
                    begin
                        ctl.mode   = CM_DELETE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    res_status = STAT_NOT_FOUND;
                end
            end
            S_DUMP:
            begin
                // The head slot is emitted and the ring turns by one each item.
                res_key  = head;
                res_pos  = FIELD_W'(dump_idx_reg);
                res_last = dump_last;
                if (out_free)
                begin
                    out_load      = 1'b1;
                    ctl.mode      = CM_ROTATE;
                    dump_idx_next = dump_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture, dump index and result payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key;
        end
        dump_idx_reg <= dump_idx_next;
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_key_reg    <= res_key;
            out_pos_reg    <= res_pos;
            out_count_reg  <= FIELD_W'(count_next);
            out_last_reg   <= res_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last        = out_last_reg;
    assign count           = count_reg;

endmodule

[sim/key_table_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ============================================================================
// key_table_scoreboard_pkg: expected results for the sorted key table bench
// Keeps its own copy of the sorted table and predicts the result items of
// every accepted request. It then checks the response items in order, field
// by field.
// ============================================================================
package key_table_scoreboard_pkg;
    import skt_pkg::*;

    localparam int TABLE_DEPTH = CAPACITY_DEFAULT;

    // One predicted response item.
    typedef struct {
        status_t status;
        key_t    key_out;
        field_t  position;
        field_t  entry_count;
        logic    last;
    } table_result_t;

    class key_table_scoreboard;
        key_t          slots[TABLE_DEPTH];
        int unsigned   fill;
        table_result_t expected_results[$];
        int unsigned   mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned count();
            return fill;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        // Picks one of the keys currently held, so that lookups can hit.
        function key_t stored_key();
            return slots[$urandom_range(0, fill - 1)];
        endfunction

        // Queues one expected result, with the count taken after the update.
        function void push_result(status_t st, key_t k, int unsigned pos, logic lst);
            table_result_t r;
            r.status      = st;
            r.key_out     = k;
            r.position    = field_t'(pos);
            r.entry_count = field_t'(fill);
            r.last        = lst;
            expected_results.push_back(r);
        endfunction

        // Applies one accepted request to the table copy and queues its results.
        function void note_request(opcode_t op, key_t k);
            int unsigned pos;
            int unsigned i;
            if (op == OP_INSERT)
            begin
                if (fill >= TABLE_DEPTH)
                begin
                    push_result(STAT_FULL, '0, 0, 1'b1);
                    return;
                end
                // First index not below the key: the new key goes before equals.
                pos = 0;
                while (pos < fill && slots[pos] < k)
                    pos++;
                for (i = fill; i > pos; i--)
                    slots[i] = slots[i - 1];
                slots[pos] = k;
                fill++;
                push_result(STAT_OK, k, pos, 1'b1);
                return;
            end
            if (fill == 0)
            begin
                push_result(STAT_EMPTY, '0, 0, 1'b1);
                return;
            end
            if (op == OP_DUMP)
            begin
                for (i = 0; i < fill; i++)
                    push_result(STAT_OK, slots[i], i, (i + 1 == fill));
                return;
            end
            // Search and delete act on the lowest index holding the key.
            pos = 0;
            while (pos < fill && slots[pos] < k)
                pos++;
            if (pos >= fill || slots[pos] != k)
            begin
                push_result(STAT_NOT_FOUND, '0, 0, 1'b1);
                return;
            end
            if (op == OP_DELETE)
            begin
                for (i = pos; i + 1 < fill; i++)
                    slots[i] = slots[i + 1];
                fill--;
            end
            push_result(STAT_OK, k, pos, 1'b1);
        endfunction

        // Compares one accepted response item with the oldest expectation.
        function void check_result(status_t st, key_t k, field_t pos, field_t cnt,
                                   logic lst);
            table_result_t r;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item: status %0d key_out %06h", st, k);
                mismatches++;
                return;
            end
            r = expected_results.pop_front();
            if (st !== r.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", r.status, st);
                mismatches++;
            end
            if (k !== r.key_out)
            begin
                $error("key_out mismatch: expected %06h, actual %06h", r.key_out, k);
                mismatches++;
            end
            if (pos !== r.position)
            begin
                $error("position mismatch: expected %0d, actual %0d", r.position, pos);
                mismatches++;
            end
            if (cnt !== r.entry_count)
            begin
                $error("entry_count mismatch: expected %0d, actual %0d",
                       r.entry_count, cnt);
                mismatches++;
            end
            if (lst !== r.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", r.last, lst);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[sim/tb_sorted_key_table_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_sorted_key_table_core: self-checking bench for the sorted key table
// Drives insert, search, delete and dump requests, first a directed set of
// corner cases and then random traffic, under varying back-pressure. Every
// response item is checked against a scoreboard that tracks the table.
// ============================================================================
module tb_sorted_key_table_core;
    import skt_pkg::*;
    import key_table_scoreboard_pkg::*;

    localparam int          TABLE_DEPTH = CAPACITY_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          SETTLE_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned rcv_idle_pct;

    key_table_scoreboard sb;

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock generation.
    always #4 clk = ~clk;

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Both handshakes are sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            sb.note_request(req_ch.opcode, req_ch.key);
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.status, rsp_ch.key_out, rsp_ch.position,
                            rsp_ch.entry_count, rsp_ch.last);
    end

    // Presents one request item and returns at the falling edge after it is taken.
    task automatic send_item(input opcode_t op, input key_t k);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.opcode = op;
        req_ch.key    = k;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain_results();
        req_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mixes stored keys, a small pool of near-duplicates and fully random keys.
    function automatic key_t pick_key();
        int unsigned kr;
        kr = $urandom_range(0, 99);
        if (kr < 45 && sb.count() > 0)
            return sb.stored_key();
        else if (kr < 70)
            return {8'($urandom_range(8'h61, 8'h64)), 16'h6100};
        else
            return key_t'($urandom());
    endfunction

    // One random request, biased towards operations that hit the table.
    task automatic random_item();
        int unsigned r;
        opcode_t     op;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = OP_INSERT;
        else if (r < 65)
            op = OP_SEARCH;
        else if (r < 88)
            op = OP_DELETE;
        else
            op = OP_DUMP;
        send_item(op, pick_key());
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 24;
        rcv_idle_pct  = 59;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_INSERT;
        req_ch.key    = '0;
        rsp_ch.ready  = 1'b0;
        sb            = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Operations on an empty table.
        send_item(OP_DUMP,   24'h000000);
        send_item(OP_SEARCH, 24'h123456);
        send_item(OP_DELETE, 24'h000000);

        // Extreme keys, a duplicate and keys in between.
        send_item(OP_INSERT, 24'h414243);
        send_item(OP_INSERT, 24'h000000);
        send_item(OP_INSERT, 24'hFFFFFF);
        send_item(OP_INSERT, 24'h414243);
        send_item(OP_INSERT, 24'h410000);

        // Hits on the duplicate, the head and the tail, and a miss.
        send_item(OP_SEARCH, 24'h414243);
        send_item(OP_SEARCH, 24'h414244);
        send_item(OP_SEARCH, 24'hFFFFFF);
        send_item(OP_SEARCH, 24'h000000);
        send_item(OP_DUMP,   24'hFFFFFF);

        // Deletes of the head, the tail, the first duplicate and a missing key.
        send_item(OP_DELETE, 24'h000000);
        send_item(OP_DELETE, 24'hFFFFFF);
        send_item(OP_DELETE, 24'h414243);
        send_item(OP_DELETE, 24'h7A7A7A);
        send_item(OP_SEARCH, 24'h414243);
        send_item(OP_INSERT, 24'h800000);
        send_item(OP_INSERT, 24'h7FFFFF);
        send_item(OP_DUMP,   24'h000000);

        // Empty the table again.
        send_item(OP_DELETE, 24'h410000);
        send_item(OP_DELETE, 24'h414243);
        send_item(OP_DELETE, 24'h800000);
        send_item(OP_DELETE, 24'h7FFFFF);
        send_item(OP_DUMP,   24'h000000);
        drain_results();

        // Sender light on gaps, receiver heavily stalled.
        repeat (20) random_item();
        drain_results();

        // Roles swapped: fill the table, overfill it, then take it apart.
        send_idle_pct = 59;
        rcv_idle_pct  = 24;
        while (sb.count() < TABLE_DEPTH)
            send_item(OP_INSERT, pick_key());
        send_item(OP_INSERT, pick_key());
        send_item(OP_INSERT, 24'h000000);
        send_item(OP_SEARCH, sb.stored_key());
        send_item(OP_DUMP,   24'h000000);
        repeat (6) send_item(OP_DELETE, sb.stored_key());
        repeat (15) random_item();
        drain_results();

        // No idling on either side.
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        repeat (20) random_item();
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
